// ===== rtl/core/grid_move_range_distance_core_macros.svh =====
// ----------------------------------------------------------------------------
// grid_move_range_distance_core_macros
// Assertion macros shared by the core RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_MOVE_RANGE_DISTANCE_CORE_MACROS_SVH
`define GRID_MOVE_RANGE_DISTANCE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GMRD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmrd: implication check failed");
`define GMRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmrd: next-cycle check failed");
`else
`define GMRD_ASSERT_IMPL(label, ante, cons)
`define GMRD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/gmrd_pkg.sv =====
// ----------------------------------------------------------------------------
// gmrd_pkg
// Types, codes and constants of the grid move range distance core.
// ----------------------------------------------------------------------------
package gmrd_pkg;

    localparam int GMRD_MAX_COLS = 64;
    localparam int GMRD_MAX_ROWS = 64;

    localparam logic [16:0] COST_ORTHO = 17'd256;
    localparam logic [16:0] COST_DIAG  = 17'd362;

    localparam logic [3:0] STEP_LAST = 4'd9;

    // direction j, clockwise from up
    localparam logic [7:0] DIR_UP    = 8'b1000_0011;
    localparam logic [7:0] DIR_RIGHT = 8'b0000_1110;
    localparam logic [7:0] DIR_DOWN  = 8'b0011_1000;
    localparam logic [7:0] DIR_LEFT  = 8'b1110_0000;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_code_t;

    typedef enum logic [1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_DIFF_THRESH = 2'd2,
        CFG_MAX_MOVE    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LINK,
        ST_DIST
    } state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [11:0]        cell_req;
        logic signed [15:0] cell_height;
    } in_item_t;

    typedef struct packed {
        logic [15:0] distance;
        logic        reachable;
        logic [3:0]  neighbor_count;
    } out_item_t;

    function automatic logic [3:0] popcount8(input logic [7:0] m);
        logic [3:0] n;
        n = 4'd0;
        for (int j = 0; j < 8; j++) begin
            n = n + {3'd0, m[j]};
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/gmrd_ram.sv =====
// ----------------------------------------------------------------------------
// gmrd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gmrd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/grid_move_range_distance_core.sv =====
// ----------------------------------------------------------------------------
// grid_move_range_distance_core
// Height grid store with 8-connected link and shortest distance passes.
// ----------------------------------------------------------------------------
// A write request is answered from the result register; a read request
// passes through the RAM read, then the result register. After reset the
// link and distance RAMs are swept once over all MAX_COLS*MAX_ROWS entries,
// with input stalled. A run request clears all MAX_COLS*MAX_ROWS entries,
// links each cell in use, then runs relaxation sweeps over them; sweeps
// repeat until one changes nothing, so a run grows with the longest path in
// steps. Each cell visit is bound by the single read port of the height,
// link and distance RAMs (own entry plus eight neighbours).
module grid_move_range_distance_core
    import gmrd_pkg::*;
#(
    parameter int MAX_COLS = GMRD_MAX_COLS,
    parameter int MAX_ROWS = GMRD_MAX_ROWS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

`include "grid_move_range_distance_core_macros.svh"

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int PW    = CW + RW;
    localparam int DRW   = 17;

    // configuration
    logic [6:0]  gw_reg, gh_reg;
    logic [15:0] thr_reg, maxm_reg;

    // control
    state_t          state_reg, state_next;
    logic            run_reg, run_next;
    logic [3:0]      step_reg, step_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [RW-1:0]   row_reg, row_next, h_reg, h_next;
    logic [CW-1:0]   col_reg, col_next, w_reg, w_next;
    logic [NW-1:0]   cells_reg, cells_next;
    logic            changed_reg, changed_next;
    logic            out_valid_reg, out_valid_next;

    // datapath
    logic signed [15:0] hself_reg, hself_next;
    logic [7:0]         mask_reg, mask_next;
    logic [15:0]        best_reg, best_next;
    logic               bestv_reg, bestv_next;
    logic               upd_reg, upd_next;
    logic               oob_reg, oob_next;
    out_item_t          out_data_reg, out_data_next;

    // RAM ports
    logic [AW-1:0]  rd_addr;
    logic           h_we, l_we, dist_we;
    logic [AW-1:0]  h_waddr, l_waddr, dist_waddr;
    logic [15:0]    h_wdata, height_rdata;
    logic [7:0]     l_wdata, link_rdata;
    logic [DRW-1:0] dist_wdata, dist_rdata;

    logic          in_accept;
    logic          clr_last, step_last, cell_last;
    logic [2:0]    dir_i, dir_d;
    logic [AW-1:0] cell_addr;
    logic          cell_oob;
    logic [CW-1:0] w_clamp;
    logic [RW-1:0] h_clamp;
    logic [PW-1:0] cells_prod;
    logic signed [16:0] hdiff;
    logic [16:0]   habs;
    logic          link_hit;
    logic [7:0]    mask_upd;
    logic [16:0]   dcand;
    logic          dist_hit;
    logic [15:0]   best_upd;
    logic          bestv_upd, upd_upd, sweep_changed;
    logic          walking, coord_ok;

    function automatic logic [AW-1:0] nbr_addr(input logic [AW-1:0] base,
                                               input logic [2:0] dir,
                                               input logic [CW-1:0] w);
        logic [AW-1:0] a;
        a = base;
        if (DIR_UP[dir])    a = a - AW'(w);
        if (DIR_DOWN[dir])  a = a + AW'(w);
        if (DIR_LEFT[dir])  a = a - AW'(1);
        if (DIR_RIGHT[dir]) a = a + AW'(1);
        return a;
    endfunction

    function automatic logic in_grid(input logic [2:0] dir,
                                     input logic [RW-1:0] r, input logic [CW-1:0] c,
                                     input logic [RW-1:0] h, input logic [CW-1:0] w);
        logic ok;
        ok = 1'b1;
        if (DIR_UP[dir] && r == '0)                 ok = 1'b0;
        if (DIR_DOWN[dir] && r == RW'(h - RW'(1)))  ok = 1'b0;
        if (DIR_LEFT[dir] && c == '0)               ok = 1'b0;
        if (DIR_RIGHT[dir] && c == CW'(w - CW'(1))) ok = 1'b0;
        return ok;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cell_addr = AW'(in_data.cell_req);
    assign cell_oob  = 32'(in_data.cell_req) >= CELLS;
    assign w_clamp = (gw_reg < 7'd2) ? CW'(2) :
                     ((32'(gw_reg) > MAX_COLS) ? CW'(MAX_COLS) : CW'(gw_reg));
    assign h_clamp = (gh_reg < 7'd2) ? RW'(2) :
                     ((32'(gh_reg) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(gh_reg));
    assign cells_prod = PW'(w_clamp) * PW'(h_clamp);

    assign clr_last  = idx_reg == AW'(CELLS - 1);
    assign step_last = step_reg == STEP_LAST;
    assign cell_last = (NW'(idx_reg) + NW'(1)) == cells_reg;
    assign dir_i     = 3'(step_reg - 4'd1);
    assign dir_d     = 3'(step_reg - 4'd2);

    assign walking  = (state_reg == ST_LINK) || (state_reg == ST_DIST);
    assign coord_ok = (col_reg < w_reg) && (row_reg < h_reg) && (step_reg <= STEP_LAST);

    // link test against the neighbour height now on the read port
    assign hdiff    = {hself_reg[15], hself_reg} - {height_rdata[15], height_rdata};
    assign habs     = hdiff[16] ? 17'(-hdiff) : 17'(hdiff);
    assign link_hit = (step_reg >= 4'd2) && in_grid(dir_d, row_reg, col_reg, h_reg, w_reg)
                      && (habs < {1'b0, thr_reg});
    assign mask_upd = mask_reg | (link_hit ? (8'd1 << dir_d) : 8'd0);

    // relaxation: pull from linked neighbour
    assign dcand    = {1'b0, dist_rdata[15:0]} + (dir_d[0] ? COST_DIAG : COST_ORTHO);
    assign dist_hit = (step_reg >= 4'd2) && mask_reg[dir_d] && dist_rdata[DRW-1]
                      && (dcand < {1'b0, maxm_reg})
                      && (!bestv_reg || dcand[15:0] < best_reg);
    assign best_upd      = dist_hit ? dcand[15:0] : best_reg;
    assign bestv_upd     = bestv_reg || dist_hit;
    assign upd_upd       = upd_reg || dist_hit;
    assign sweep_changed = changed_reg || upd_upd;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = run_reg ? ST_LINK : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept && in_data.op == OP_RUN)
                begin
                    state_next = ST_CLEAR;
                end
                else if (in_accept && in_data.op == OP_READ)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_LINK:
            begin
                if (step_last && cell_last)
                begin
                    state_next = ST_DIST;
                end
            end
            ST_DIST:
            begin
                if (step_last && cell_last && !sweep_changed)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        run_next       = run_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        cells_next     = cells_reg;
        changed_next   = changed_reg;
        hself_next     = hself_reg;
        mask_next      = mask_reg;
        best_next      = best_reg;
        bestv_next     = bestv_reg;
        upd_next       = upd_reg;
        oob_next       = oob_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        rd_addr    = idx_reg;
        h_we       = 1'b0;
        h_waddr    = cell_addr;
        h_wdata    = in_data.cell_height;
        l_we       = 1'b0;
        l_waddr    = idx_reg;
        l_wdata    = 8'd0;
        dist_we    = 1'b0;
        dist_waddr = idx_reg;
        dist_wdata = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                l_we    = 1'b1;
                dist_we = 1'b1;
                idx_next = clr_last ? '0 : idx_reg + AW'(1);
                if (clr_last)
                begin
                    row_next  = '0;
                    col_next  = '0;
                    step_next = '0;
                end
            end
            ST_IDLE:
            begin
                rd_addr  = cell_addr;
                oob_next = cell_oob;
                if (in_accept)
                begin
                    unique case (in_data.op)
                        OP_WRITE:
                        begin
                            h_we           = !cell_oob;
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                        OP_RUN:
                        begin
                            run_next   = 1'b1;
                            idx_next   = '0;
                            w_next     = w_clamp;
                            h_next     = h_clamp;
                            cells_next = NW'(cells_prod);
                        end
                        OP_READ:
                        begin
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '0;
                if (!oob_reg)
                begin
                    out_data_next.distance       = dist_rdata[DRW-1] ? dist_rdata[15:0] : 16'd0;
                    out_data_next.reachable      = dist_rdata[DRW-1];
                    out_data_next.neighbor_count = popcount8(link_rdata);
                end
            end
            ST_LINK, ST_DIST:
            begin
                if (step_reg != 4'd0 && !step_last)
                begin
                    rd_addr = nbr_addr(idx_reg, dir_i, w_reg);
                end
                if (step_reg == 4'd1)
                begin
                    hself_next = height_rdata;
                    mask_next  = (state_reg == ST_LINK) ? 8'd0 : link_rdata;
                    best_next  = dist_rdata[15:0];
                    bestv_next = dist_rdata[DRW-1];
                    upd_next   = 1'b0;
                end
                else if (step_reg != 4'd0)
                begin
                    mask_next  = (state_reg == ST_LINK) ? mask_upd : mask_reg;
                    best_next  = best_upd;
                    bestv_next = bestv_upd;
                    upd_next   = upd_upd;
                end
                step_next = step_last ? 4'd0 : step_reg + 4'd1;
                if (step_last)
                begin
                    if (state_reg == ST_LINK)
                    begin
                        l_we    = 1'b1;
                        l_wdata = mask_upd;
                        if (cell_last)
                        begin
                            // seed the centre cell
                            dist_we      = 1'b1;
                            dist_waddr   = AW'(cells_reg >> 1);
                            dist_wdata   = {1'b1, 16'd0};
                            changed_next = 1'b0;
                        end
                    end
                    else
                    begin
                        dist_we      = upd_upd;
                        dist_wdata   = {1'b1, best_upd};
                        changed_next = sweep_changed;
                        if (cell_last)
                        begin
                            changed_next = 1'b0;
                            if (!sweep_changed)
                            begin
                                run_next       = 1'b0;
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                            end
                        end
                    end
                    if (cell_last)
                    begin
                        idx_next = '0;
                        row_next = '0;
                        col_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                        if (col_reg == CW'(w_reg - CW'(1)))
                        begin
                            col_next = '0;
                            row_next = row_reg + RW'(1);
                        end
                        else
                        begin
                            col_next = col_reg + CW'(1);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            run_reg       <= 1'b0;
            step_reg      <= '0;
            idx_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            w_reg         <= CW'(2);
            h_reg         <= RW'(2);
            cells_reg     <= NW'(4);
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            gw_reg        <= 7'd15;
            gh_reg        <= 7'd15;
            thr_reg       <= 16'd26;
            maxm_reg      <= 16'd1536;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            w_reg         <= w_next;
            h_reg         <= h_next;
            cells_reg     <= cells_next;
            changed_reg   <= changed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH:  gw_reg   <= cfg_data[6:0];
                    CFG_GRID_HEIGHT: gh_reg   <= cfg_data[6:0];
                    CFG_DIFF_THRESH: thr_reg  <= cfg_data;
                    CFG_MAX_MOVE:    maxm_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hself_reg    <= hself_next;
        mask_reg     <= mask_next;
        best_reg     <= best_next;
        bestv_reg    <= bestv_next;
        upd_reg      <= upd_next;
        oob_reg      <= oob_next;
        out_data_reg <= out_data_next;
    end

    gmrd_ram #(.WIDTH(16), .DEPTH(CELLS)) u_height_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (rd_addr),
        .rdata (height_rdata)
    );

    gmrd_ram #(.WIDTH(8), .DEPTH(CELLS)) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    gmrd_ram #(.WIDTH(DRW), .DEPTH(CELLS)) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (rd_addr),
        .rdata (dist_rdata)
    );

    `GMRD_ASSERT_IMPL(a_read_slot_free, state_reg == ST_READ, !out_valid_reg)
    `GMRD_ASSERT_NEXT(a_read_answers, state_reg == ST_READ, out_valid_reg)
    `GMRD_ASSERT_IMPL(a_dist_write_valid, dist_we && state_reg == ST_DIST, dist_wdata[DRW-1])
    `GMRD_ASSERT_IMPL(a_coord_in_grid, walking, coord_ok)

endmodule

// ===== bench/tb_grid_move_range_distance_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_move_range_distance_core
// Self-checking bench for the height grid link and distance core: a queue fed
// driver sends write, run, read and unused requests under random back-pressure;
// a monitor compares every result with a predictor holding its own grid state.
// ----------------------------------------------------------------------------
module tb_grid_move_range_distance_core
    import gmrd_pkg::*;
();

    localparam int NCELLS     = GMRD_MAX_COLS * GMRD_MAX_ROWS;
    localparam int FILL_CELLS = 256;
    localparam int MAX_CYCLE  = 8000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    grid_move_range_distance_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted grid state
    logic [15:0] grid_h [NCELLS];
    logic [7:0]  grid_link [NCELLS];
    logic [15:0] grid_dist [NCELLS];
    bit          grid_reach [NCELLS];
    logic [6:0]  p_width;
    logic [6:0]  p_height;
    logic [15:0] p_thresh;
    logic [15:0] p_max_move;

    const int step_dr [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    const int step_dc [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

    in_item_t  pending_req [$];
    out_item_t expected_res [$];

    int  send_idle;
    int  rcv_idle;
    bit  hold_off;
    int  errors;
    int  checked;
    int  n_runs;
    int  n_reads;
    int  n_writes;
    int  cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_dim(input logic [6:0] v);
        if (v < 7'd2)
            return 2;
        if (v > 7'd64)
            return 64;
        return int'(v);
    endfunction

    // link pass, then relaxation sweeps until nothing improves
    function automatic void run_link_relax();
        int w;
        int h;
        int cells;
        int idx;
        int nidx;
        int nr;
        int nc;
        int diff;
        int d;
        bit changed;
        w = clamp_dim(p_width);
        h = clamp_dim(p_height);
        cells = w * h;
        for (int i = 0; i < NCELLS; i++)
        begin
            grid_link[i] = 8'd0;
            grid_dist[i] = 16'd0;
            grid_reach[i] = 1'b0;
        end
        for (int r = 0; r < h; r++)
        begin
            for (int c = 0; c < w; c++)
            begin
                idx = r * w + c;
                for (int j = 0; j < 8; j++)
                begin
                    nr = r + step_dr[j];
                    nc = c + step_dc[j];
                    if (nr < 0 || nc < 0 || nr >= h || nc >= w)
                        continue;
                    diff = int'($signed(grid_h[idx])) - int'($signed(grid_h[nr * w + nc]));
                    if (diff < 0)
                        diff = -diff;
                    if (diff < int'(p_thresh))
                        grid_link[idx][j] = 1'b1;
                end
            end
        end
        grid_reach[cells / 2] = 1'b1;
        do
        begin
            changed = 1'b0;
            for (int i = 0; i < cells; i++)
            begin
                if (!grid_reach[i])
                    continue;
                for (int j = 0; j < 8; j++)
                begin
                    if (!grid_link[i][j])
                        continue;
                    nidx = (i / w + step_dr[j]) * w + (i % w + step_dc[j]);
                    d = int'(grid_dist[i]) + ((j % 2 == 1) ? 362 : 256);
                    if (d < int'(p_max_move) && (!grid_reach[nidx] || d < int'(grid_dist[nidx])))
                    begin
                        grid_dist[nidx] = d[15:0];
                        grid_reach[nidx] = 1'b1;
                        changed = 1'b1;
                    end
                end
            end
        end
        while (changed);
    endfunction

    function automatic out_item_t predict_result(input in_item_t req);
        out_item_t res;
        res = '0;
        case (op_code_t'(req.op))
            OP_WRITE:
            begin
                grid_h[req.cell_req] = req.cell_height;
                n_writes++;
            end
            OP_RUN:
            begin
                run_link_relax();
                n_runs++;
            end
            OP_READ:
            begin
                n_reads++;
                if (grid_reach[req.cell_req])
                begin
                    res.distance = grid_dist[req.cell_req];
                    res.reachable = 1'b1;
                end
                for (int j = 0; j < 8; j++)
                    res.neighbor_count += {3'd0, grid_link[req.cell_req][j]};
            end
            default: ;
        endcase
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_res.insert(expected_res.size(), predict_result(in_data));
            if (!in_valid || !in_stall)
            begin
                if (pending_req.size() > 0 && !hold_off && $urandom_range(99) >= send_idle)
                begin
                    in_data  <= pending_req[0];
                    in_valid <= 1'b1;
                    pending_req.delete(0);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_res.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, out_data);
                end
                else
                begin
                    out_item_t exp_res;
                    exp_res = expected_res[0];
                    expected_res.delete(0);
                    checked++;
                    if (out_data.distance !== exp_res.distance)
                    begin
                        errors++;
                        $display("%0t: distance expected %0d got %0d", $time,
                                 exp_res.distance, out_data.distance);
                    end
                    if (out_data.reachable !== exp_res.reachable)
                    begin
                        errors++;
                        $display("%0t: reachable expected %0d got %0d", $time,
                                 exp_res.reachable, out_data.reachable);
                    end
                    if (out_data.neighbor_count !== exp_res.neighbor_count)
                    begin
                        errors++;
                        $display("%0t: neighbor_count expected %0d got %0d", $time,
                                 exp_res.neighbor_count, out_data.neighbor_count);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("grid_move_range_distance_core: mismatch");
            $finish;
        end
    end

    function automatic logic [15:0] rand_height();
        if ($urandom_range(99) < 85)
            return 16'($urandom_range(60)) - 16'd30;
        return 16'($urandom);
    endfunction

    function automatic in_item_t mk_req(input op_code_t op, input int cell_idx,
                                        input logic [15:0] hv);
        in_item_t req;
        req.op = op;
        req.cell_req = cell_idx[11:0];
        req.cell_height = hv;
        return req;
    endfunction

    function automatic void enqueue_req(input in_item_t req);
        pending_req.insert(pending_req.size(), req);
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_req.size() > 0 || in_valid || expected_res.size() > 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GRID_WIDTH:  p_width = val[6:0];
            CFG_GRID_HEIGHT: p_height = val[6:0];
            CFG_DIFF_THRESH: p_thresh = val;
            default:         p_max_move = val;
        endcase
    endtask

    task automatic set_grid(input int w, input int h, input int thr, input int mm);
        write_reg(CFG_GRID_WIDTH, 16'(w));
        write_reg(CFG_GRID_HEIGHT, 16'(h));
        write_reg(CFG_DIFF_THRESH, 16'(thr));
        write_reg(CFG_MAX_MOVE, 16'(mm));
    endtask

    // random mix: writes and reads dominate, runs rare since each is long
    task automatic random_burst(input int count, input int run_pct);
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < run_pct)
                enqueue_req(mk_req(OP_RUN, $urandom_range(4095), 16'($urandom)));
            else if (pick < run_pct + 4)
                enqueue_req(mk_req(OP_NONE, $urandom_range(4095), 16'($urandom)));
            else if (pick < 52)
                enqueue_req(mk_req(OP_WRITE, $urandom_range(4095), rand_height()));
            else
                enqueue_req(mk_req(OP_READ, $urandom_range(4095), 16'($urandom)));
        end
        enqueue_req(mk_req(OP_RUN, 0, 16'd0));
        for (int k = 0; k < 12; k++)
            enqueue_req(mk_req(OP_READ, $urandom_range(300), 16'd0));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GRID_WIDTH;
        cfg_data = 16'd0;
        send_idle = 27;
        rcv_idle = 74;
        hold_off = 1'b0;
        errors = 0;
        checked = 0;
        n_runs = 0;
        n_reads = 0;
        n_writes = 0;
        cycle_count = 0;
        p_width = 7'd15;
        p_height = 7'd15;
        p_thresh = 16'd26;
        p_max_move = 16'd1536;
        for (int i = 0; i < NCELLS; i++)
        begin
            grid_h[i] = 16'd0;
            grid_link[i] = 8'd0;
            grid_dist[i] = 16'd0;
            grid_reach[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reads before any run, unused opcode, extreme cells
        enqueue_req(mk_req(OP_READ, 0, 16'hFFFF));
        enqueue_req(mk_req(OP_READ, 4095, 16'h0000));
        enqueue_req(mk_req(OP_NONE, 4095, 16'hFFFF));
        enqueue_req(mk_req(OP_NONE, 0, 16'h0000));
        // load every cell that any grid size below reaches
        for (int i = 0; i < FILL_CELLS; i++)
            enqueue_req(mk_req(OP_WRITE, i, rand_height()));
        enqueue_req(mk_req(OP_WRITE, 0, 16'h8000));
        enqueue_req(mk_req(OP_WRITE, 1, 16'h7FFF));
        enqueue_req(mk_req(OP_WRITE, 4095, 16'h8000));
        enqueue_req(mk_req(OP_RUN, 0, 16'd0));
        enqueue_req(mk_req(OP_READ, 112, 16'd0));
        enqueue_req(mk_req(OP_READ, 0, 16'd0));
        enqueue_req(mk_req(OP_READ, 1, 16'd0));
        enqueue_req(mk_req(OP_READ, 224, 16'd0));
        enqueue_req(mk_req(OP_READ, 225, 16'd0));
        enqueue_req(mk_req(OP_READ, 4095, 16'd0));
        enqueue_req(mk_req(OP_NONE, 2730, 16'h5555));
        random_burst(50, 5);
        wait_drained();

        // clamped to 2x2, largest link threshold and distance bound
        set_grid(0, 1, 65535, 65535);
        random_burst(25, 6);
        // sender holds until every request so far has answered
        hold_off = 1'b1;
        do
            @(negedge clk);
        while (expected_res.size() > 0 || in_valid);
        hold_off = 1'b0;
        random_burst(25, 6);
        wait_drained();

        set_grid(7, 9, 40, 2000);
        random_burst(40, 6);
        wait_drained();

        send_idle = 74;
        rcv_idle = 27;
        set_grid(64, 3, 0, 0);
        random_burst(30, 5);
        wait_drained();

        // oversize height register clamps to the maximum row count
        set_grid(2, 127, 30, 65535);
        random_burst(30, 5);
        wait_drained();

        send_idle = 0;
        rcv_idle = 0;
        // oversize width register clamps to the maximum column count
        set_grid(127, 2, 65535, 700);
        random_burst(30, 0);
        wait_drained();

        set_grid(15, 15, 26, 1536);
        random_burst(30, 6);
        wait_drained();

        $display("Covered %0d writes, %0d runs, %0d reads; %0d results checked.",
                 n_writes, n_runs, n_reads, checked);
        $display("Grid sizes from clamped 2x2 to 64 columns or 64 rows, bounds at both ends.");
        if (errors == 0)
            $display("grid_move_range_distance_core: match");
        else
            $display("grid_move_range_distance_core: mismatch");
        $finish;
    end

endmodule

// ===== grid_move_range_distance_core.f =====
+incdir+rtl/core
rtl/core/gmrd_pkg.sv
rtl/core/gmrd_ram.sv
rtl/core/grid_move_range_distance_core.sv
bench/tb_grid_move_range_distance_core.sv
